// ----- rtl/core/keyword_maneuver_classifier_defines.svh -----
// Assertion macros shared by the keyword maneuver classifier RTL.
`ifndef KEYWORD_MANEUVER_CLASSIFIER_DEFINES_SVH
`define KEYWORD_MANEUVER_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define KMC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kmc: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define KMC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kmc: next-cycle check failed");
`else
`define KMC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KMC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/kmc_pkg.sv -----
// Shared constants, types and keyword table of the keyword maneuver classifier.
`timescale 1ns / 1ps

package kmc_pkg;

    localparam int CHAR_W             = 8;
    localparam int WIN_LEN            = 12;
    localparam int KW_COUNT           = 15;
    localparam int MAX_TEXT_CHARS_DEF = 95;

    // Keyword indices into the sticky flag word.
    localparam int KW_DESTINATION = 0;
    localparam int KW_ARRIVE      = 1;
    localparam int KW_ROUNDABOUT  = 2;
    localparam int KW_UDASH       = 3;
    localparam int KW_UTURN       = 4;
    localparam int KW_SLIGHT_L    = 5;
    localparam int KW_SLIGHT_R    = 6;
    localparam int KW_SHARP_L     = 7;
    localparam int KW_SHARP_R     = 8;
    localparam int KW_KEEP_L      = 9;
    localparam int KW_KEEP_R      = 10;
    localparam int KW_MERGE       = 11;
    localparam int KW_EXIT        = 12;
    localparam int KW_LEFT        = 13;
    localparam int KW_RIGHT       = 14;

    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [KW_COUNT-1:0] kw_mask_t;

    typedef enum logic [3:0] {
        MNV_STRAIGHT, MNV_DESTINATION, MNV_ROUNDABOUT, MNV_UTURN_LEFT,
        MNV_UTURN_RIGHT, MNV_SLIGHT_LEFT, MNV_SLIGHT_RIGHT, MNV_SHARP_LEFT,
        MNV_SHARP_RIGHT, MNV_KEEP_LEFT, MNV_KEEP_RIGHT, MNV_MERGE, MNV_EXIT,
        MNV_LEFT, MNV_RIGHT
    } maneuver_t;

    // Window control handed from the top level to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

    // Keywords right-aligned in a window-wide word: the final character sits in
    // the lowest byte and the unused leading bytes are zero, meaning don't care.
    localparam logic [WIN_LEN*CHAR_W-1:0] KW_TEXT [KW_COUNT] = '{
        "destination", "arrive", "roundabout", "u-turn", "uturn",
        "slight left", "slight right", "sharp left", "sharp right",
        "keep left", "keep right", "merge", "exit", "left", "right"
    };

    // Folds ASCII upper-case letters to lower case; other bytes pass unchanged.
    function automatic char_t fold_case(input char_t c);
        char_t r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/keyword_maneuver_classifier.sv -----
// Top level of the keyword maneuver classifier.
//
// The block takes an instruction text one character per transfer, one transfer
// every clock cycle, with no gaps between texts. Characters shift through a row
// of twelve window cells; each cell compares the byte it receives against the
// keyword characters for its position, and the combined hits set sticky flags
// in the same cycle, so the one-byte-per-cycle rate is set by that window shift.
// The transfer marked with tlast ends the text: its maneuver code appears on the
// result channel in the following cycle from an output register, and the window
// and flags are empty for the next text at once. Characters without tlast are
// taken even while a result is still waiting; a final character waits only for
// a stalled result to be taken. A zero byte stops matching for the rest of the
// text, and only the first MAX_TEXT_CHARS characters are matched.
`timescale 1ns / 1ps
`include "keyword_maneuver_classifier_defines.svh"

module keyword_maneuver_classifier
    import kmc_pkg::*;
#(
    parameter int MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [3:0] maneuver, [7:4] zero
);

    localparam int CNT_W = $clog2(MAX_TEXT_CHARS + 1);

    char_t            cell_din [WIN_LEN];
    char_t            cell_q   [WIN_LEN];
    kw_mask_t         cell_match [WIN_LEN];
    win_ctrl_t        ctrl;
    kw_mask_t         hits;
    kw_mask_t         seen_reg, seen_next, seen_final;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             stopped_reg, stopped_next;
    logic             m_valid_reg, m_valid_next;
    maneuver_t        maneuver_reg, maneuver_next, resolved;
    logic             in_xfer, last_xfer, take_char;

    // Input handshake: only a final character needs room in the output register.
    assign s_tready  = !m_valid_reg || m_tready || !s_tlast;
    assign in_xfer   = s_tvalid && s_tready;
    assign last_xfer = in_xfer && s_tlast;
    assign take_char = in_xfer && !stopped_reg && (s_tdata != '0)
                       && (count_reg < CNT_W'(MAX_TEXT_CHARS));

    assign ctrl.shift = take_char;
    assign ctrl.clear = last_xfer;

    // Row of window cells, newest character entering at the top position.
    for (genvar p = 0; p < WIN_LEN; p++) begin : g_cell
        if (p == WIN_LEN - 1) begin : g_head
            assign cell_din[p] = fold_case(s_tdata);
        end else begin : g_body
            assign cell_din[p] = cell_q[p + 1];
        end
        kmc_cell #(.POS(p)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .din     (cell_din[p]),
            .q       (cell_q[p]),
            .match   (cell_match[p])
        );
    end

    // A keyword hits when every cell agrees with it.
    always_comb begin
        hits = '1;
        for (int p = 0; p < WIN_LEN; p++) begin
            hits = hits & cell_match[p];
        end
    end

    assign seen_final = take_char ? (seen_reg | hits) : seen_reg;

    kmc_resolve u_resolve (
        .seen     (seen_final),
        .maneuver (resolved)
    );

    // Text state: flags, character count and the zero-byte stop.
    always_comb begin
        seen_next    = seen_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        if (last_xfer) begin
            seen_next    = '0;
            count_next   = '0;
            stopped_next = 1'b0;
        end else if (in_xfer) begin
            seen_next = seen_final;
            if (take_char) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (!stopped_reg && (s_tdata == '0)) begin
                stopped_next = 1'b1;
            end
        end
    end

    // Output register for the result transfer.
    always_comb begin
        m_valid_next  = m_valid_reg;
        maneuver_next = maneuver_reg;
        if (last_xfer) begin
            m_valid_next  = 1'b1;
            maneuver_next = resolved;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        maneuver_reg <= maneuver_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, maneuver_reg};

    // A final character leaves an empty text state and a pending result.
    `KMC_ASSERT_NXT(a_clear_on_last, aclk, aresetn, last_xfer,
        (seen_reg == '0) && (count_reg == '0) && !stopped_reg && m_valid_reg)
    // The count never passes the text limit.
    `KMC_ASSERT_IMP(a_count_limit, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(MAX_TEXT_CHARS))
    // Once stopped, further characters of the text change nothing.
    `KMC_ASSERT_NXT(a_stopped_hold, aclk, aresetn, in_xfer && !s_tlast && stopped_reg,
        $stable(count_reg) && $stable(seen_reg) && stopped_reg)
    // A pending result always carries a defined maneuver code.
    `KMC_ASSERT_IMP(a_code_range, aclk, aresetn, m_valid_reg,
        m_tdata[3:0] <= 4'(MNV_RIGHT))

endmodule

// ----- rtl/core/kmc_cell.sv -----
// One window position: holds a character and compares its incoming byte.
`timescale 1ns / 1ps

module kmc_cell
    import kmc_pkg::*;
#(
    parameter int POS = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  win_ctrl_t ctrl,
    input  char_t     din,
    output char_t     q,
    output kw_mask_t  match
);

    localparam int OFS = (WIN_LEN - 1 - POS) * CHAR_W;

    char_t byte_reg;
    char_t byte_next;

    // Per-keyword test of the byte this cell holds after the shift. A keyword
    // that does not reach this position gives a zero byte and always agrees.
    always_comb begin
        char_t kb;
        for (int k = 0; k < KW_COUNT; k++) begin
            kb       = KW_TEXT[k][OFS +: CHAR_W];
            match[k] = (kb == '0) || (din == kb);
        end
    end

    // Take the neighbour's byte on a shift, empty on the end of a text.
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = '0;
        end else if (ctrl.shift) begin
            byte_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

// ----- rtl/core/kmc_resolve.sv -----
// Priority encoder from the sticky keyword flags to one maneuver code.
`timescale 1ns / 1ps

module kmc_resolve
    import kmc_pkg::*;
(
    input  kw_mask_t  seen,
    output maneuver_t maneuver
);

    // Highest priority first; a U-turn takes its side from the word right.
    always_comb begin
        if (seen[KW_DESTINATION] || seen[KW_ARRIVE]) begin
            maneuver = MNV_DESTINATION;
        end else if (seen[KW_ROUNDABOUT]) begin
            maneuver = MNV_ROUNDABOUT;
        end else if (seen[KW_UDASH] || seen[KW_UTURN]) begin
            maneuver = seen[KW_RIGHT] ? MNV_UTURN_RIGHT : MNV_UTURN_LEFT;
        end else if (seen[KW_SLIGHT_L]) begin
            maneuver = MNV_SLIGHT_LEFT;
        end else if (seen[KW_SLIGHT_R]) begin
            maneuver = MNV_SLIGHT_RIGHT;
        end else if (seen[KW_SHARP_L]) begin
            maneuver = MNV_SHARP_LEFT;
        end else if (seen[KW_SHARP_R]) begin
            maneuver = MNV_SHARP_RIGHT;
        end else if (seen[KW_KEEP_L]) begin
            maneuver = MNV_KEEP_LEFT;
        end else if (seen[KW_KEEP_R]) begin
            maneuver = MNV_KEEP_RIGHT;
        end else if (seen[KW_MERGE]) begin
            maneuver = MNV_MERGE;
        end else if (seen[KW_EXIT]) begin
            maneuver = MNV_EXIT;
        end else if (seen[KW_LEFT]) begin
            maneuver = MNV_LEFT;
        end else if (seen[KW_RIGHT]) begin
            maneuver = MNV_RIGHT;
        end else begin
            maneuver = MNV_STRAIGHT;
        end
    end

endmodule

// ----- verif/maneuver_checker.sv -----
// Checker for the keyword maneuver classifier: predicts each maneuver code and compares results.
`timescale 1ns / 1ps

module maneuver_checker
    import kmc_pkg::*;
#(
    parameter int MAX_CHARS = MAX_TEXT_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // last_char
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [3:0] maneuver, [7:4] zero
    output int         errors,
    output int         outstanding
);

    // Keyword spellings, in the order of the flag bits.
    string kw_words [KW_COUNT] = '{
        "destination", "arrive", "roundabout", "u-turn", "uturn",
        "slight left", "slight right", "sharp left", "sharp right",
        "keep left", "keep right", "merge", "exit", "left", "right"
    };

    // Shadow copy of the text state of the block.
    logic [7:0] text_win [WIN_LEN];
    kw_mask_t   kw_seen;
    logic [7:0] chars_taken;
    logic       text_halted;

    // Maneuver codes still owed by the block, oldest first.
    maneuver_t  maneuver_q [$];
    maneuver_t  want_mnv;
    int         fail_count = 0;

    assign errors = fail_count;

    task automatic report(input string what);
        fail_count++;
        $display("maneuver_checker: %s (at %0t)", what, $time);
    endtask

    // Empties the window and the flags, as at reset and after each final character.
    task automatic clear_text();
        for (int i = 0; i < WIN_LEN; i++) begin
            text_win[i] = 8'h00;
        end
        kw_seen     = '0;
        chars_taken = 8'd0;
        text_halted = 1'b0;
    endtask

    // Folds the case, shifts the byte in and sets the flag of every keyword ending here.
    task automatic shift_in_char(input logic [7:0] raw);
        logic [7:0] c;
        int         len;
        bit         hit;
        c = raw;
        // Only the letters A to Z are folded.
        if (raw >= 8'h41 && raw <= 8'h5A) begin
            c = raw + 8'h20;
        end
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            text_win[i] = text_win[i + 1];
        end
        text_win[WIN_LEN - 1] = c;
        for (int k = 0; k < KW_COUNT; k++) begin
            len = kw_words[k].len();
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
                if (text_win[WIN_LEN - len + j] != kw_words[k][j]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kw_seen[k] = 1'b1;
            end
        end
    endtask

    // Fixed priority from the flags to one maneuver code.
    function automatic maneuver_t classify_flags(input kw_mask_t f);
        if (f[KW_DESTINATION] || f[KW_ARRIVE]) return MNV_DESTINATION;
        if (f[KW_ROUNDABOUT]) return MNV_ROUNDABOUT;
        if (f[KW_UDASH] || f[KW_UTURN]) return f[KW_RIGHT] ? MNV_UTURN_RIGHT : MNV_UTURN_LEFT;
        if (f[KW_SLIGHT_L]) return MNV_SLIGHT_LEFT;
        if (f[KW_SLIGHT_R]) return MNV_SLIGHT_RIGHT;
        if (f[KW_SHARP_L]) return MNV_SHARP_LEFT;
        if (f[KW_SHARP_R]) return MNV_SHARP_RIGHT;
        if (f[KW_KEEP_L]) return MNV_KEEP_LEFT;
        if (f[KW_KEEP_R]) return MNV_KEEP_RIGHT;
        if (f[KW_MERGE]) return MNV_MERGE;
        if (f[KW_EXIT]) return MNV_EXIT;
        if (f[KW_LEFT]) return MNV_LEFT;
        if (f[KW_RIGHT]) return MNV_RIGHT;
        return MNV_STRAIGHT;
    endfunction

    // Both channels are sampled at the rising edge, before any update of that edge lands.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_text();
            maneuver_q.delete();
        end else begin
            // Result transfer: compare with the oldest code owed.
            if (m_tvalid && m_tready) begin
                if (maneuver_q.size() == 0) begin
                    report($sformatf("result 0x%02h with none expected", m_tdata));
                end else begin
                    want_mnv = maneuver_q.pop_front();
                    if (m_tdata[3:0] != want_mnv) begin
                        report($sformatf("maneuver %0d, expected %0d (%s)",
                                         m_tdata[3:0], want_mnv, want_mnv.name()));
                    end
                    if (m_tdata[7:4] != 4'h0) begin
                        report($sformatf("padding bits 0x%01h not zero", m_tdata[7:4]));
                    end
                end
            end
            // Character transfer: a zero byte halts matching, long texts are cut short.
            if (s_tvalid && s_tready) begin
                if (!text_halted) begin
                    if (s_tdata == 8'h00) begin
                        text_halted = 1'b1;
                    end else if (chars_taken < MAX_CHARS) begin
                        shift_in_char(s_tdata);
                        chars_taken = chars_taken + 8'd1;
                    end
                end
                if (s_tlast) begin
                    maneuver_q.push_back(classify_flags(kw_seen));
                    clear_text();
                end
            end
        end
        outstanding <= maneuver_q.size();
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the keyword maneuver classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_CHARS   = 95;
    localparam int CYCLE_LIMIT = 400000;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] char_code
    logic       s_tlast;    // last_char
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [3:0] maneuver, [7:4] zero

    int          errors;
    int          outstanding;
    int unsigned cycle_count = 0;

    // Text being assembled, sent as one run of transfers with tlast on its final byte.
    logic [7:0] text_buf [$];
    int         chars_sent = 0;
    int         texts_sent = 0;

    // The first fifteen are the keywords; the rest are fillers and near misses.
    string phrases [26] = '{
        "destination", "arrive", "roundabout", "u-turn", "uturn",
        "slight left", "slight right", "sharp left", "sharp right",
        "keep left", "keep right", "merge", "exit", "left", "right",
        "turn", "onto", "the", "street", "at", "lef", "righ", "u-tur",
        "keep", "slight", "sharp"
    };

    keyword_maneuver_classifier #(
        .MAX_TEXT_CHARS(MAX_CHARS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    maneuver_checker #(
        .MAX_CHARS(MAX_CHARS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Guard against a hung handshake.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(10, 25);
    endfunction

    // Result side back-pressure, held for random stretches.
    int ready_left = 0;
    int ready_pick;

    initial m_tready = 1'b0;

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_pick = $urandom_range(99);
            if (ready_pick < 50) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 20);
            end else if (ready_pick < 85) begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(1, 3);
            end else if (ready_pick < 95) begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(5, 30);
            end else begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(40, 80);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // One character transfer; tvalid stays high into the next one when there is no gap.
    task automatic send_char(input logic [7:0] c, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_text(input bit burst);
        for (int i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1, burst);
            chars_sent++;
        end
        text_buf.delete();
        texts_sent++;
    endtask

    // Appends a word, optionally with random letters raised to upper case.
    task automatic add_word(input string w, input bit mix);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (mix && c >= 8'h61 && c <= 8'h7A && $urandom_range(3) == 0) begin
                c = c - 8'h20;
            end
            text_buf.push_back(c);
        end
    endtask

    // Holds the sender off until every owed result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int kind;
        int ntok;
        int rand_texts;
        int pad;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // A zero byte that is itself the final character.
        text_buf.push_back(8'h00);
        send_text(1'b0);
        // Top byte value on its own.
        text_buf.push_back(8'hFF);
        send_text(1'b0);
        // Upper-case keyword is folded before matching.
        add_word("EXIT", 1'b0);
        send_text(1'b0);
        // A keyword after a zero byte is ignored.
        text_buf.push_back(8'h00);
        add_word("left", 1'b0);
        send_text(1'b0);
        // Bytes on either side of the upper-case range and its two ends.
        add_word("@AZ[`{", 1'b0);
        send_text(1'b1);
        add_word("RiGhT", 1'b0);
        send_text(1'b0);
        drain();

        // Random texts: mostly phrases, some over-long, the rest raw bytes.
        rand_texts = 0;
        while (chars_sent < 500 || rand_texts < 24) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                ntok = $urandom_range(1, 4);
                for (int t = 0; t < ntok; t++) begin
                    if ($urandom_range(99) < 60) begin
                        add_word(phrases[$urandom_range(14)], 1'b1);
                    end else begin
                        add_word(phrases[$urandom_range(15, 25)], 1'b1);
                    end
                    if (t < ntok - 1 && $urandom_range(4) != 0) begin
                        text_buf.push_back(8'h20);
                    end
                end
                if ($urandom_range(9) == 0) begin
                    text_buf.insert($urandom_range(text_buf.size()), 8'h00);
                end
            end else if (kind < 71) begin
                // Keyword near the character limit, which may fall partly or wholly past it.
                pad = $urandom_range(82, 96);
                for (int i = 0; i < pad; i++) begin
                    text_buf.push_back(8'($urandom_range(32, 126)));
                end
                add_word(phrases[$urandom_range(14)], 1'b1);
            end else begin
                ntok = $urandom_range(1, 12);
                for (int i = 0; i < ntok; i++) begin
                    text_buf.push_back(8'($urandom_range(255)));
                end
            end
            send_text($urandom_range(3) == 0);
            rand_texts++;
            if (rand_texts == 10) begin
                drain();
            end
        end

        // Let the last results arrive, then wait for strays before the verdict.
        drain();
        repeat (8) @(posedge aclk);
        if (outstanding != 0) begin
            $display("tb: %0d results never arrived", outstanding);
        end
        if (errors == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- keyword_maneuver_classifier.f -----
+incdir+rtl/core
rtl/core/kmc_pkg.sv
rtl/core/kmc_cell.sv
rtl/core/kmc_resolve.sv
rtl/core/keyword_maneuver_classifier.sv
verif/maneuver_checker.sv
verif/tb.sv
